FILE: design/fwss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fwss_pkg;

	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 16;

	localparam logic [7:0] AngleMin = 8'd10;
	localparam logic [7:0] AngleMax = 8'd170;
	localparam logic [7:0] WindMax = 8'd180;

	typedef enum logic [CfgIdxW-1:0] {
		REG_MAX_PICTURES  = 3'd0,
		REG_WIND_DELAY    = 3'd1,
		REG_WIND_STOP     = 3'd2,
		REG_WIND_OFFSET   = 3'd3,
		REG_SHUTTER_HOME  = 3'd4,
		REG_SHUTTER_STEP  = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		CMD_UPDATE = 2'd0,
		CMD_READY  = 2'd1,
		CMD_RELOAD = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		PH_UNWOUND  = 2'd0,
		PH_WINDING  = 2'd1,
		PH_WOUND    = 2'd2,
		PH_PRESSING = 2'd3
	} phase_t;

	typedef struct packed {
		logic [7:0]        max_pictures;
		logic [15:0]       wind_delay_ms;
		logic [7:0]        wind_stop_position;
		logic signed [7:0] wind_speed_offset;
		logic [7:0]        shutter_home_position;
		logic signed [6:0] shutter_step;
	} cfg_t;

	typedef struct packed {
		logic [1:0] phase;
		logic [7:0] wind_command;
		logic [7:0] shutter_angle;
		logic [7:0] pictures_left;
		logic       servo_busy;
	} res_t;

endpackage

`default_nettype wire

FILE: design/film_wind_shutter_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

// Camera wind and shutter sequencer. Each input transfer (update tick, ready
// request or reload) updates the state in the cycle it is taken and yields one
// result, registered in the output buffer, carrying the state after that item.
// One item is taken every cycle while in_stall is low; the two-entry output buffer
// lets a new item in while one result waits, and in_stall rises only when both
// entries are held by a stalled output. Configuration writes via
// cfg_we/cfg_index/cfg_data take effect at the next edge; indexes 6 and 7 are ignored.
module film_wind_shutter_sequencer import fwss_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [1:0]          cmd,
	input  wire logic                switch_closed,
	input  wire logic [31:0]         now_ms,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [1:0]               phase,
	output logic [7:0]               wind_command,
	output logic [7:0]               shutter_angle,
	output logic [7:0]               pictures_left,
	output logic                     servo_busy
);

	cfg_t cfg_q;
	res_t core_res, out_res;
	logic accept, buf_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_pictures          <= 8'd27;
			cfg_q.wind_delay_ms         <= 16'd1000;
			cfg_q.wind_stop_position    <= 8'd90;
			cfg_q.wind_speed_offset     <= 8'sd10;
			cfg_q.shutter_home_position <= 8'd10;
			cfg_q.shutter_step          <= 7'sd5;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_PICTURES: cfg_q.max_pictures          <= cfg_data[7:0];
				REG_WIND_DELAY:   cfg_q.wind_delay_ms         <= cfg_data;
				REG_WIND_STOP:    cfg_q.wind_stop_position    <= cfg_data[7:0];
				REG_WIND_OFFSET:  cfg_q.wind_speed_offset     <= $signed(cfg_data[7:0]);
				REG_SHUTTER_HOME: cfg_q.shutter_home_position <= cfg_data[7:0];
				REG_SHUTTER_STEP: cfg_q.shutter_step          <= $signed(cfg_data[6:0]);
				default: ;
			endcase
		end
	end

	assign in_stall = buf_full;
	assign accept   = in_valid && !buf_full;

	fwss_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.cmd           (cmd),
		.switch_closed (switch_closed),
		.now_ms        (now_ms),
		.cfg           (cfg_q),
		.res           (core_res)
	);

	fwss_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (core_res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_res)
	);

	assign phase         = out_res.phase;
	assign wind_command  = out_res.wind_command;
	assign shutter_angle = out_res.shutter_angle;
	assign pictures_left = out_res.pictures_left;
	assign servo_busy    = out_res.servo_busy;

endmodule

`default_nettype wire

FILE: design/fwss_core.sv
`timescale 1ns / 1ps
`default_nettype none

module fwss_core import fwss_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire logic [1:0]  cmd,
	input  wire logic        switch_closed,
	input  wire logic [31:0] now_ms,
	input  wire cfg_t        cfg,
	output res_t             res
);

	phase_t      phase_q, phase_d;
	logic        ready_q, ready_d;
	logic [7:0]  count_q, count_d;
	logic [31:0] last_shot_q, last_shot_d;
	logic [7:0]  shutter_q, shutter_d;
	logic        running_q, running_d;

	logic [7:0]        home_angle;
	logic signed [9:0] shut_sum;
	logic [7:0]        shut_next;
	logic [31:0]       elapsed;
	logic [7:0]        stop_sat;
	logic signed [9:0] wind_sum;
	logic [7:0]        wind_sat;

	always_comb begin
		if (cfg.shutter_home_position < AngleMin) begin
			home_angle = AngleMin;
		end else if (cfg.shutter_home_position > AngleMax) begin
			home_angle = AngleMax;
		end else begin
			home_angle = cfg.shutter_home_position;
		end
	end

	assign shut_sum = $signed({2'b00, shutter_q})
		+ $signed({{3{cfg.shutter_step[6]}}, cfg.shutter_step});

	always_comb begin
		if (shut_sum < $signed({2'b00, AngleMin})) begin
			shut_next = AngleMin;
		end else if (shut_sum > $signed({2'b00, AngleMax})) begin
			shut_next = AngleMax;
		end else begin
			shut_next = shut_sum[7:0];
		end
	end

	assign elapsed = now_ms - last_shot_q;

	always_comb begin
		phase_d     = phase_q;
		ready_d     = ready_q;
		count_d     = count_q;
		last_shot_d = last_shot_q;
		shutter_d   = shutter_q;
		running_d   = running_q;
		case (cmd)
			CMD_UPDATE: begin
				unique case (phase_q)
					PH_UNWOUND: begin
						shutter_d = home_angle;
						if (elapsed > {16'd0, cfg.wind_delay_ms} && ready_q
								&& count_q != 8'd0) begin
							phase_d = PH_WINDING;
							ready_d = 1'b0;
						end
					end
					PH_WINDING: begin
						running_d = 1'b1;
						if (switch_closed) begin
							phase_d   = PH_WOUND;
							running_d = 1'b0;
							ready_d   = 1'b0;
						end
					end
					PH_WOUND: begin
						running_d = 1'b0;
						if (ready_q) begin
							phase_d = PH_PRESSING;
							ready_d = 1'b0;
						end
					end
					PH_PRESSING: begin
						shutter_d = shut_next;
						if (!switch_closed) begin
							if (count_q != 8'd0) begin
								count_d = count_q - 8'd1;
							end
							phase_d     = PH_UNWOUND;
							last_shot_d = now_ms;
							ready_d     = 1'b0;
						end
					end
					default: ;
				endcase
			end
			CMD_READY: begin
				ready_d = (phase_q == PH_UNWOUND) || (phase_q == PH_WOUND);
			end
			CMD_RELOAD: begin
				count_d   = cfg.max_pictures;
				running_d = 1'b0;
				shutter_d = home_angle;
				phase_d   = switch_closed ? PH_WOUND : PH_UNWOUND;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_UNWOUND;
			ready_q     <= 1'b0;
			count_q     <= 8'd0;
			last_shot_q <= 32'd0;
			shutter_q   <= AngleMin;
			running_q   <= 1'b0;
		end else if (accept) begin
			phase_q     <= phase_d;
			ready_q     <= ready_d;
			count_q     <= count_d;
			last_shot_q <= last_shot_d;
			shutter_q   <= shutter_d;
			running_q   <= running_d;
		end
	end

	// wind command follows the state after this item
	assign stop_sat = (cfg.wind_stop_position > WindMax) ? WindMax : cfg.wind_stop_position;
	assign wind_sum = $signed({2'b00, cfg.wind_stop_position})
		+ $signed({{2{cfg.wind_speed_offset[7]}}, cfg.wind_speed_offset});

	always_comb begin
		if (wind_sum[9]) begin
			wind_sat = 8'd0;
		end else if (wind_sum > $signed({2'b00, WindMax})) begin
			wind_sat = WindMax;
		end else begin
			wind_sat = wind_sum[7:0];
		end
	end

	assign res.phase         = phase_d;
	assign res.wind_command  = running_d ? wind_sat : stop_sat;
	assign res.shutter_angle = shutter_d;
	assign res.pictures_left = count_d;
	assign res.servo_busy    = (phase_d == PH_WINDING) || (phase_d == PH_PRESSING);

	a_running_only_winding: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> phase_q == PH_WINDING)
		else $error("wind servo running outside winding");

	a_shutter_range: assert property (@(posedge clk) disable iff (!arst_n)
		shutter_q >= AngleMin && shutter_q <= AngleMax)
		else $error("shutter angle out of range");

	a_count_only_reload_raises: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd != CMD_RELOAD |=> count_q <= $past(count_q))
		else $error("picture count rose without reload");

endmodule

`default_nettype wire

FILE: design/fwss_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none

module fwss_out_buf import fwss_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire res_t push_data,
	output logic      full,
	output logic      out_valid,
	input  wire logic out_stall,
	output res_t      out_data
);

	logic main_valid_q, skid_valid_q;
	res_t main_q, skid_q;
	logic pop;

	assign pop       = main_valid_q && !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (!main_valid_q) begin
			main_valid_q <= push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload: move skid forward on pop, else catch the new transfer
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else begin
				main_q <= push_data;
			end
		end else if (!main_valid_q) begin
			main_q <= push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	a_skid_needs_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("skid holds data while main stage is empty");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> !push)
		else $error("transfer into full buffer");

	a_stalled_holds: assert property (@(posedge clk) disable iff (!arst_n)
		main_valid_q && out_stall |=> main_valid_q && main_q == $past(main_q))
		else $error("stalled result changed");

endmodule

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench import fwss_pkg::*; ();

	localparam logic [1:0]         CmdSpare   = 2'd3;
	localparam logic [CfgIdxW-1:0] RegSpareA  = 3'd6;
	localparam logic [CfgIdxW-1:0] RegSpareB  = 3'd7;
	localparam int                 CycleLimit = 200000;
	localparam int                 HoldCycles = 60;

	class shot_scoreboard;
		logic [7:0]        max_pics;
		logic [15:0]       delay;
		logic [7:0]        stop;
		logic signed [7:0] offset;
		logic [7:0]        home;
		logic signed [6:0] step;

		phase_t      ph;
		bit          ready;
		logic [7:0]  count;
		logic [31:0] last_shot;
		logic [7:0]  shutter;
		bit          wind_on;

		res_t pending_results[$];
		int   errors;

		function new();
			max_pics = 8'd27;
			delay = 16'd1000;
			stop = 8'd90;
			offset = 8'sd10;
			home = 8'd10;
			step = 7'sd5;
			ph = PH_UNWOUND;
			ready = 1'b0;
			count = 8'd0;
			last_shot = 32'd0;
			shutter = 8'd10;
			wind_on = 1'b0;
			errors = 0;
		endfunction

		function int clampi(int v, int lo, int hi);
			if (v < lo)
				return lo;
			if (v > hi)
				return hi;
			return v;
		endfunction

		function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
			case (idx)
				REG_MAX_PICTURES: max_pics = data[7:0];
				REG_WIND_DELAY:   delay = data;
				REG_WIND_STOP:    stop = data[7:0];
				REG_WIND_OFFSET:  offset = data[7:0];
				REG_SHUTTER_HOME: home = data[7:0];
				REG_SHUTTER_STEP: step = data[6:0];
				default: ;
			endcase
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction

		// advance the camera state by one transfer and queue the state it shows
		function void note_item(logic [1:0] c, logic sw, logic [31:0] t);
			logic [31:0] since;
			res_t        r;
			since = t - last_shot;
			if (c == CMD_UPDATE) begin
				case (ph)
					PH_UNWOUND: begin
						shutter = 8'(clampi(int'(home), AngleMin, AngleMax));
						if (since > {16'd0, delay} && ready && count != 0) begin
							ph = PH_WINDING;
							ready = 1'b0;
						end
					end
					PH_WINDING: begin
						wind_on = 1'b1;
						if (sw) begin
							ph = PH_WOUND;
							wind_on = 1'b0;
							ready = 1'b0;
						end
					end
					PH_WOUND: begin
						wind_on = 1'b0;
						if (ready) begin
							ph = PH_PRESSING;
							ready = 1'b0;
						end
					end
					default: begin
						shutter = 8'(clampi(int'(shutter) + int'(step), AngleMin, AngleMax));
						if (!sw) begin
							if (count != 0)
								count = count - 8'd1;
							ph = PH_UNWOUND;
							last_shot = t;
							ready = 1'b0;
						end
					end
				endcase
			end else if (c == CMD_READY) begin
				ready = !(ph == PH_WINDING || ph == PH_PRESSING);
			end else if (c == CMD_RELOAD) begin
				count = max_pics;
				wind_on = 1'b0;
				shutter = 8'(clampi(int'(home), AngleMin, AngleMax));
				ph = sw ? PH_WOUND : PH_UNWOUND;
			end
			r.phase = ph;
			if (wind_on)
				r.wind_command = 8'(clampi(int'(stop) + int'(offset), 0, WindMax));
			else
				r.wind_command = 8'(clampi(int'(stop), 0, WindMax));
			r.shutter_angle = shutter;
			r.pictures_left = count;
			r.servo_busy = (ph == PH_WINDING || ph == PH_PRESSING);
			pending_results.push_back(r);
		endfunction

		function void cmp_field(string name, int want, int got);
			if (want != got) begin
				errors++;
				$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: expected no result, got %p", $time, got);
				return;
			end
			want = pending_results.pop_front();
			cmp_field("phase", want.phase, got.phase);
			cmp_field("wind_command", want.wind_command, got.wind_command);
			cmp_field("shutter_angle", want.shutter_angle, got.shutter_angle);
			cmp_field("pictures_left", want.pictures_left, got.pictures_left);
			cmp_field("servo_busy", want.servo_busy, got.servo_busy);
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [1:0]          cmd = '0;
	logic                switch_closed = 1'b0;
	logic [31:0]         now_ms = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [1:0]          phase;
	logic [7:0]          wind_command;
	logic [7:0]          shutter_angle;
	logic [7:0]          pictures_left;
	logic                servo_busy;

	shot_scoreboard sb = new();
	res_t           seen;
	bit             hold_req = 1'b0;
	bit             no_idle = 1'b0;
	logic [31:0]    stamp = '0;
	int             cycles = 0;

	film_wind_shutter_sequencer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.switch_closed(switch_closed),
		.now_ms(now_ms),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.phase(phase),
		.wind_command(wind_command),
		.shutter_angle(shutter_angle),
		.pictures_left(pictures_left),
		.servo_busy(servo_busy)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	// check the result first: an input taken at this edge cannot show up yet
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			seen.phase = phase;
			seen.wind_command = wind_command;
			seen.shutter_angle = shutter_angle;
			seen.pictures_left = pictures_left;
			seen.servo_busy = servo_busy;
			sb.check_result(seen);
		end
		if (in_valid && !in_stall)
			sb.note_item(cmd, switch_closed, now_ms);
	end

	always begin
		@(negedge clk);
		if (hold_req) begin
			out_stall <= 1'b1;
			repeat (HoldCycles) @(negedge clk);
			hold_req = 1'b0;
			out_stall <= 1'b0;
		end else if (!no_idle && $urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			repeat ($urandom_range(1, 4)) @(negedge clk);
			out_stall <= 1'b0;
		end
	end

	task automatic send_item(input logic [1:0] c, input logic sw, input logic [31:0] t);
		if (!no_idle && $urandom_range(0, 4) == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 3)) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		cmd <= c;
		switch_closed <= sw;
		now_ms <= t;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, data);
	endtask

	task automatic configure(input int p);
		logic [7:0]  pics;
		logic [7:0]  stop_v;
		logic [7:0]  off_v;
		logic [7:0]  home_v;
		logic [15:0] dly;
		logic [6:0]  stp;
		case (p)
			0: begin
				pics = 8'd255; dly = 16'hFFFF; stop_v = 8'd255;
				off_v = 8'h7F; home_v = 8'd255; stp = 7'h3F;
			end
			1: begin
				pics = 8'd0; dly = 16'd0; stop_v = 8'd0;
				off_v = 8'h80; home_v = 8'd0; stp = 7'h40;
			end
			2: begin
				pics = 8'd3; dly = 16'd0; stop_v = 8'd180;
				off_v = 8'hA6; home_v = 8'd170; stp = 7'h20;
			end
			default: begin
				pics = ($urandom_range(0, 7) == 0) ? 8'd255 : 8'($urandom_range(1, 12));
				dly = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
				stop_v = 8'($urandom);
				off_v = 8'($urandom);
				home_v = 8'($urandom);
				stp = 7'($urandom);
			end
		endcase
		// upper data bits carry noise that the narrow registers must drop
		write_cfg(REG_MAX_PICTURES, {8'($urandom), pics});
		write_cfg(REG_WIND_DELAY, dly);
		write_cfg(REG_WIND_STOP, {8'($urandom), stop_v});
		write_cfg(REG_WIND_OFFSET, {8'($urandom), off_v});
		write_cfg(REG_SHUTTER_HOME, {8'($urandom), home_v});
		write_cfg(REG_SHUTTER_STEP, {9'($urandom), stp});
		write_cfg(RegSpareA, 16'($urandom));
		write_cfg(RegSpareB, 16'($urandom));
	endtask

	// steer toward the next phase most of the time so shot cycles run to completion
	task automatic pick_item(output logic [1:0] c, output logic sw, output logic [31:0] t);
		int r;
		r = $urandom_range(0, 99);
		sw = 1'($urandom_range(0, 1));
		t = stamp + $urandom_range(0, 20);
		c = CMD_UPDATE;
		if (r < 12) begin
			c = 2'($urandom_range(0, 3));
			if (r < 3)
				t = $urandom();
		end else begin
			case (sb.ph)
				PH_UNWOUND: begin
					if (sb.count == 0) begin
						c = CMD_RELOAD;
					end else if (!sb.ready) begin
						c = CMD_READY;
					end else begin
						c = CMD_UPDATE;
						t = stamp + $urandom_range(0, 2 * int'(sb.delay) + 2);
					end
				end
				PH_WINDING: sw = ($urandom_range(0, 2) == 0);
				PH_WOUND:   c = sb.ready ? CMD_UPDATE : CMD_READY;
				default:    sw = ($urandom_range(0, 3) != 0);
			endcase
		end
		stamp = t;
	endtask

	initial begin
		int          p;
		int          k;
		logic [1:0]  c;
		logic        sw;
		logic [31:0] t;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		send_item(CmdSpare, 1'b0, 32'd0);
		send_item(CMD_UPDATE, 1'b0, 32'hFFFF_FFFF);
		send_item(CMD_READY, 1'b0, 32'd0);
		// no pictures yet: no winding however long ago the last shot
		send_item(CMD_UPDATE, 1'b0, 32'd2000);
		send_item(CMD_RELOAD, 1'b0, 32'd0);
		// delay reached but not exceeded
		send_item(CMD_UPDATE, 1'b0, 32'd1000);
		send_item(CMD_UPDATE, 1'b0, 32'd1001);
		send_item(CMD_READY, 1'b0, 32'd1002);
		send_item(CMD_UPDATE, 1'b0, 32'd1003);
		send_item(CMD_UPDATE, 1'b1, 32'd1004);
		send_item(CMD_UPDATE, 1'b1, 32'd1005);
		send_item(CMD_READY, 1'b1, 32'd1006);
		send_item(CMD_UPDATE, 1'b1, 32'd1007);
		send_item(CMD_UPDATE, 1'b1, 32'd1008);
		// reload in the middle of a press
		send_item(CMD_RELOAD, 1'b1, 32'd1009);
		send_item(CMD_READY, 1'b1, 32'd1010);
		send_item(CMD_UPDATE, 1'b1, 32'd1011);
		send_item(CMD_UPDATE, 1'b0, 32'hFFFF_FFF0);
		send_item(CMD_READY, 1'b0, 32'hFFFF_FFF1);
		// timestamp wraps past zero after the shot
		send_item(CMD_UPDATE, 1'b0, 32'd5);
		send_item(CMD_UPDATE, 1'b0, 32'h0000_03D9);
		send_item(CMD_UPDATE, 1'b0, 32'h0000_03DA);
		send_item(CMD_RELOAD, 1'b0, 32'h0000_03DB);
		send_item(CmdSpare, 1'b1, 32'hFFFF_FFFF);
		stamp = 32'h0000_0400;

		for (p = 0; p < 10; p++) begin
			drain_results();
			configure(p);
			if (p == 9)
				no_idle = 1'b1;
			for (k = 0; k < 200; k++) begin
				if (p == 4 && k == 20)
					hold_req = 1'b1;
				if (p == 6 && k == 100)
					drain_results();
				pick_item(c, sw, t);
				send_item(c, sw, t);
			end
		end

		drain_results();
		repeat (4) @(posedge clk);
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
